>>> src/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg: shared types and constants for the tape machine step unit
// Opcodes, tape geometry, stage record and pointer wrap helper.
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int TAPE_CELLS = 32768;
	localparam int CODE_DEPTH = 4096;
	localparam int PTR_W      = $clog2(TAPE_CELLS);
	localparam int POS_W      = 12;
	// working width for pointer arithmetic, covers 2*TAPE_CELLS and the 8-bit move
	localparam int MV_W       = ((PTR_W > 8) ? PTR_W : 8) + 2;

	typedef enum logic [2:0] {
		OP_MOVE  = 3'd0,
		OP_ADD   = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_JZ    = 3'd4,
		OP_JNZ   = 3'd5,
		OP_END   = 3'd6,
		OP_ABORT = 3'd7
	} op_t;

	// instruction as held in the execute stage
	typedef struct packed {
		op_t              op;
		logic [7:0]       amount;
		logic [7:0]       in_byte;
		logic             in_eof;
		logic [POS_W-1:0] jump_target;
		logic [PTR_W-1:0] idx;
		logic             active;   // not halted before this request
		logic             halted;   // halt flag after this request
	} item_t;

	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		logic [7:0]       data;
	} tape_wr_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             out_valid;
		logic             jump_taken;
		logic [POS_W-1:0] next_position;
		logic             halted;
		logic             aborted;
	} res_t;

	// pointer + signed 8-bit move, modulo TAPE_CELLS
	function automatic logic [PTR_W-1:0] ptr_move(input logic [PTR_W-1:0] p,
		input logic [7:0] amt);
		logic [MV_W-1:0] m;
		logic [MV_W-1:0] step;
		logic [MV_W-1:0] sum;
		m = amt[7] ? (MV_W'(256) - MV_W'(amt)) : MV_W'(amt[6:0]);
		// magnitude is at most 128, TAPE_CELLS at least 16: eight steps suffice
		for (int i = 0; i < 8; i++) begin
			if (m >= MV_W'(TAPE_CELLS)) m = m - MV_W'(TAPE_CELLS);
		end
		step = amt[7] ? (MV_W'(TAPE_CELLS) - m) : m;
		sum = MV_W'(p) + step;
		if (sum >= MV_W'(TAPE_CELLS)) sum = sum - MV_W'(TAPE_CELLS);
		return sum[PTR_W-1:0];
	endfunction

	// jump target modulo code depth (code depth is a power of two)
	function automatic logic [POS_W-1:0] code_wrap(input logic [POS_W-1:0] t);
		return (CODE_DEPTH >= (1 << POS_W)) ? t : (t & POS_W'(CODE_DEPTH - 1));
	endfunction

endpackage

>>> src/tms_front.sv
// ----------------------------------------------------------------------------
// tms_front: pointer and halt tracking, input register of the execute stage
// Updates pointer and halt flag as each request is accepted.
// ----------------------------------------------------------------------------
module tms_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        advance,
	input  tms_pkg::op_t                op,
	input  logic [7:0]                  amount,
	input  logic [7:0]                  in_byte,
	input  logic                        in_eof,
	input  logic [tms_pkg::POS_W-1:0]   jump_target,
	output logic [tms_pkg::PTR_W-1:0]   ptr,
	output logic                        valid_s1,
	output tms_pkg::item_t              item_s1
);

	logic [tms_pkg::PTR_W-1:0] ptr_q;
	logic                      halt_q;
	logic                      stop;

	assign ptr  = ptr_q;
	assign stop = (op == tms_pkg::OP_END) || (op == tms_pkg::OP_ABORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			halt_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (!halt_q && op == tms_pkg::OP_MOVE) ptr_q <= tms_pkg::ptr_move(ptr_q, amount);
				if (!halt_q && stop) halt_q <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op          <= op;
			item_s1.amount      <= amount;
			item_s1.in_byte     <= in_byte;
			item_s1.in_eof      <= in_eof;
			item_s1.jump_target <= jump_target;
			item_s1.idx         <= ptr_q;
			item_s1.active      <= !halt_q;
			item_s1.halted      <= halt_q || stop;
		end
	end

endmodule

>>> src/tms_tape.sv
// ----------------------------------------------------------------------------
// tms_tape: byte tape memory with post-reset clear and write forwarding
// One write and one registered read per cycle; while busy, the write port serves the clear.
// ----------------------------------------------------------------------------
module tms_tape (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [tms_pkg::PTR_W-1:0] rd_addr,
	input  tms_pkg::tape_wr_t         wr,
	output logic [7:0]                cur_byte,
	output logic                      busy
);

	logic [7:0]                mem [tms_pkg::TAPE_CELLS];
	logic [tms_pkg::PTR_W-1:0] clr_addr_q;
	logic                      busy_q;
	logic [7:0]                rd_data_s1;
	logic                      fwd_hit_s1;
	logic [7:0]                fwd_val_s1;
	tms_pkg::tape_wr_t         port;

	assign busy     = busy_q;
	assign cur_byte = fwd_hit_s1 ? fwd_val_s1 : rd_data_s1;

	always_comb begin
		if (busy_q) begin
			port.en   = 1'b1;
			port.addr = clr_addr_q;
			port.data = 8'h00;
		end else begin
			port = wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			if (clr_addr_q == tms_pkg::PTR_W'(tms_pkg::TAPE_CELLS - 1)) busy_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (port.en) mem[port.addr] <= port.data;
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			// a write landing on the same edge is not seen by the read
			fwd_hit_s1 <= port.en && (port.addr == rd_addr);
			fwd_val_s1 <= port.data;
		end
	end

endmodule

>>> src/tms_exec.sv
// ----------------------------------------------------------------------------
// tms_exec: instruction execute logic
// Computes the new cell value and the result for the staged request.
// ----------------------------------------------------------------------------
module tms_exec (
	input  tms_pkg::item_t    item,
	input  logic [7:0]        cur_byte,
	output tms_pkg::tape_wr_t wr,
	output tms_pkg::res_t     res
);

	logic zero;

	assign zero = (cur_byte == 8'h00);

	always_comb begin
		wr.en     = 1'b0;
		wr.addr   = item.idx;
		wr.data   = cur_byte;
		res       = '0;
		res.halted = item.halted;
		if (item.active) begin
			unique case (item.op)
				tms_pkg::OP_MOVE: ;
				tms_pkg::OP_ADD: begin
					wr.en   = 1'b1;
					wr.data = cur_byte + item.amount;
				end
				tms_pkg::OP_WRITE: begin
					res.out_byte  = cur_byte;
					res.out_valid = 1'b1;
				end
				tms_pkg::OP_READ: begin
					wr.en   = 1'b1;
					wr.data = item.in_eof ? 8'h00 : item.in_byte;
				end
				tms_pkg::OP_JZ, tms_pkg::OP_JNZ: begin
					if ((item.op == tms_pkg::OP_JZ) == zero) begin
						res.jump_taken    = 1'b1;
						res.next_position = tms_pkg::code_wrap(item.jump_target);
					end
				end
				tms_pkg::OP_END: ;
				tms_pkg::OP_ABORT: res.aborted = 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> src/tape_machine_step.sv
// A request accepted at an edge is registered into the execute stage (item and
// tape read), then into the output register when the execute stage advances.
// Throughput: one request per cycle unless the tape clear or res_ready holds it;
// the tape read-modify-write is one memory read at accept and one write as the
// request leaves the execute stage, with forwarding between neighbors.
// Reset: pointer and halt flag clear at once; the tape is then zeroed one cell
// a cycle, all TAPE_CELLS (32768) cells, with in_ready low throughout.
// ----------------------------------------------------------------------------
// tape_machine_step: tape machine instruction execution unit
// Front stage tracks pointer and halt, execute stage updates the tape cell,
// an output register holds the result until taken.
// ----------------------------------------------------------------------------
module tape_machine_step (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                op,
	input  logic signed [7:0]         amount,
	input  logic [7:0]                in_byte,
	input  logic                      in_eof,
	input  logic [11:0]               jump_target,
	// result channel
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [7:0]                out_byte,
	output logic                      out_valid,
	output logic                      jump_taken,
	output logic [11:0]               next_position,
	output logic                      halted,
	output logic                      aborted
);

	logic                      accept;
	logic                      advance;
	logic                      busy;
	logic                      valid_s1;
	logic [tms_pkg::PTR_W-1:0] ptr;
	logic [7:0]                cur_byte;
	tms_pkg::item_t            item_s1;
	tms_pkg::tape_wr_t         exec_wr;
	tms_pkg::tape_wr_t         wr;
	tms_pkg::res_t             res;
	tms_pkg::res_t             res_q;
	logic                      res_valid_q;

	// execute stage moves on when the output register is empty or draining
	assign advance  = !res_valid_q || res_ready;
	assign in_ready = !busy && (!valid_s1 || advance);
	assign accept   = in_valid && in_ready;

	tms_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.advance     (advance),
		.op          (tms_pkg::op_t'(op)),
		.amount      (amount),
		.in_byte     (in_byte),
		.in_eof      (in_eof),
		.jump_target (jump_target),
		.ptr         (ptr),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1)
	);

	tms_exec u_exec (
		.item     (item_s1),
		.cur_byte (cur_byte),
		.wr       (exec_wr),
		.res      (res)
	);

	// the tape is written only as the request leaves the execute stage
	always_comb begin
		wr    = exec_wr;
		wr.en = exec_wr.en && valid_s1 && advance;
	end

	tms_tape u_tape (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (ptr),
		.wr       (wr),
		.cur_byte (cur_byte),
		.busy     (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) res_q <= res;
	end

	assign res_valid     = res_valid_q;
	assign out_byte      = res_q.out_byte;
	assign out_valid     = res_q.out_valid;
	assign jump_taken    = res_q.jump_taken;
	assign next_position = res_q.next_position;
	assign halted        = res_q.halted;
	assign aborted       = res_q.aborted;

`ifndef SYNTH
	// no request is taken while the tape is being cleared
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !busy)
		else $error("request accepted during tape clear");

	// a blocked execute stage keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("execute stage dropped a stalled request");

	// an abort always reports halted
	a_abort_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && aborted |-> halted)
		else $error("abort without halt");

	// a result is at most one of write and taken jump
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(out_valid && jump_taken))
		else $error("write and jump in one result");
`endif

endmodule
